>>> rtl/tsqs_pkg.sv
// Package: shared types, constants and helper functions for the script quality scorer
`default_nettype none
package tsqs_pkg;

    // Counter width of the per-string statistics
    localparam int CNT_W   = 16;
    // Score output width and wide accumulation width
    localparam int SCORE_W = 22;
    localparam int ACC_W   = CNT_W + 8;
    // Queue between classifier and accumulator
    localparam int FIFO_DEPTH = 4;

    // Unit classes
    localparam int CLS_W   = 3;
    localparam int NUM_CLS = 8;
    localparam logic [CLS_W-1:0] CLS_CONTROL  = 3'd0;
    localparam logic [CLS_W-1:0] CLS_HANGUL   = 3'd1;
    localparam logic [CLS_W-1:0] CLS_CJK      = 3'd2;
    localparam logic [CLS_W-1:0] CLS_KANA     = 3'd3;
    localparam logic [CLS_W-1:0] CLS_HALFKANA = 3'd4;
    localparam logic [CLS_W-1:0] CLS_ASCII    = 3'd5;
    localparam logic [CLS_W-1:0] CLS_LATIN    = 3'd6;
    localparam logic [CLS_W-1:0] CLS_OTHER    = 3'd7;

    // Special code points
    localparam logic [15:0] CP_QUESTION = 16'h003F;
    localparam logic [15:0] CP_REPLACE  = 16'hFFFD;
    localparam logic [15:0] CP_EURO     = 16'h20AC;

    // Score with a replacement character present
    localparam logic signed [SCORE_W-1:0] SCORE_FFFD = SCORE_W'(-100000);

    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_unit;
    } t_in_item;

    typedef struct packed {
        logic signed [SCORE_W-1:0] quality_score;
        logic [15:0]               script_chars;
        logic [15:0]               latin1_like;
        logic [15:0]               marker_total;
        logic                      mojibake_flag;
        logic                      damage_flag;
    } t_out_item;

    // Classified unit passed from front to back
    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic             is_q;
        logic             is_fffd;
        logic             is_space;
        logic             latin_like;
        logic             last;
    } t_cls_item;

    // Saturating increment
    function automatic t_cnt sat_inc(input t_cnt v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + t_cnt'(1);
    endfunction

    // Clamp a count to 16 bits
    function automatic logic [15:0] sat16(input logic [63:0] v);
        sat16 = (v > 64'h0000_0000_0000_FFFF) ? 16'hFFFF : v[15:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/text_script_quality_scorer_unit.sv
// Top level of the text script quality scorer
// Input channel (i_valid / o_ready, i_unit): one UTF-16 code unit per transaction,
// last_unit set on the final unit of a string. The front end sorts each unit by
// range into a class and pushes it into a four-entry queue; the back end pops one
// unit per cycle and updates saturating per-string counters.
// Output channel (o_valid / i_ready, o_result): one transaction per string, issued
// after its last unit, with the score, script count, Latin-1-like count, marker
// count and the mojibake and damage flags.
// Throughput: one code unit per cycle sustained while the score pipeline has room,
// set by the back-end counter update; strings may follow each other without gaps.
// Result path: with the queue empty, the last unit is popped into the snapshot
// register, then the partial-sum register, then the output register drives o_valid.
// Stalls: while the output waits for i_ready, units that do not end a string keep
// flowing; a last unit waits in the queue until the score pipeline has room, and
// o_ready falls only when the queue fills.
// Reset (i_rst_n low, synchronous): counters, queue and pipeline valids clear;
// no transaction is pending afterwards.
`default_nettype none
module text_script_quality_scorer_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire tsqs_pkg::t_in_item   i_unit,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output tsqs_pkg::t_out_item       o_result
);

    logic                q_full;
    logic                q_push;
    logic                q_valid;
    logic                q_pop;
    tsqs_pkg::t_cls_item front_item;
    tsqs_pkg::t_cls_item back_item;

    // Classifier
    tsqs_front u_front (
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_unit   (i_unit),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_item   (front_item)
    );

    // Decoupling queue
    tsqs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (back_item)
    );

    // Accumulator and scoring
    tsqs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (back_item),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_result  (o_result)
    );

endmodule
`default_nettype wire

>>> rtl/tsqs_front.sv
// Front end: accepts code units and sorts each into its class and marker flags
`default_nettype none
module tsqs_front (
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire tsqs_pkg::t_in_item   i_unit,
    input  wire logic                 i_q_full,
    output logic                      o_push,
    output tsqs_pkg::t_cls_item       o_item
);

    logic [15:0] u;
    logic        space;
    logic        hangul;
    logic        cjk;
    logic        kana;
    logic        ctrl;

    assign u = i_unit.code_unit;

    // Handshake: take a transaction whenever the queue has room
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // Range decoders
    always_comb begin
        space  = (u >= 16'h0009 && u <= 16'h000D) || u == 16'h0020 || u == 16'h0085 ||
                 u == 16'h00A0 || u == 16'h1680 || (u >= 16'h2000 && u <= 16'h200A) ||
                 u == 16'h2028 || u == 16'h2029 || u == 16'h202F || u == 16'h205F ||
                 u == 16'h3000;
        hangul = (u >= 16'hAC00 && u <= 16'hD7AF) || (u >= 16'h1100 && u <= 16'h11FF) ||
                 (u >= 16'h3130 && u <= 16'h318F) || (u >= 16'hA960 && u <= 16'hA97F) ||
                 (u >= 16'hD7B0 && u <= 16'hD7FF);
        cjk    = (u >= 16'h3400 && u <= 16'h4DBF) || (u >= 16'h4E00 && u <= 16'h9FFF) ||
                 (u >= 16'hF900 && u <= 16'hFAFF);
        kana   = (u >= 16'h3040 && u <= 16'h30FF) || (u >= 16'h31F0 && u <= 16'h31FF);
        ctrl   = (u < 16'h0020 && !space) || (u >= 16'h007F && u <= 16'h009F);
    end

    // Class priority: control first, other last
    always_comb begin
        priority if (ctrl) begin
            o_item.cls = tsqs_pkg::CLS_CONTROL;
        end else if (hangul) begin
            o_item.cls = tsqs_pkg::CLS_HANGUL;
        end else if (cjk) begin
            o_item.cls = tsqs_pkg::CLS_CJK;
        end else if (kana) begin
            o_item.cls = tsqs_pkg::CLS_KANA;
        end else if (u >= 16'hFF66 && u <= 16'hFF9D) begin
            o_item.cls = tsqs_pkg::CLS_HALFKANA;
        end else if (u < 16'h0080) begin
            o_item.cls = tsqs_pkg::CLS_ASCII;
        end else if (u >= 16'h00A0 && u <= 16'h00FF) begin
            o_item.cls = tsqs_pkg::CLS_LATIN;
        end else begin
            o_item.cls = tsqs_pkg::CLS_OTHER;
        end
        o_item.is_q       = (u == tsqs_pkg::CP_QUESTION);
        o_item.is_fffd    = (u == tsqs_pkg::CP_REPLACE);
        o_item.is_space   = space;
        o_item.latin_like = (u >= 16'h00A0 && u <= 16'h00FF) || u == tsqs_pkg::CP_EURO;
        o_item.last       = i_unit.last_unit;
    end

endmodule
`default_nettype wire

>>> rtl/tsqs_fifo.sv
// Short queue of classified units between front end and accumulator
`default_nettype none
module tsqs_fifo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire tsqs_pkg::t_cls_item  i_item,
    output logic                      o_full,
    output logic                      o_valid,
    input  wire logic                 i_pop,
    output tsqs_pkg::t_cls_item       o_item
);

    localparam int D  = tsqs_pkg::FIFO_DEPTH;
    localparam int PW = $clog2(D);
    localparam int CW = $clog2(D + 1);

    tsqs_pkg::t_cls_item r_mem [D];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(D));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(D - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(D - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

>>> rtl/tsqs_back.sv
// Back end: per-string counters, score pipeline and output register
`default_nettype none
module tsqs_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  wire tsqs_pkg::t_cls_item  i_item,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output tsqs_pkg::t_out_item       o_result
);

    localparam int CW = tsqs_pkg::CNT_W;
    localparam int AW = tsqs_pkg::ACC_W;
    localparam int SW = tsqs_pkg::SCORE_W;
    localparam int NC = tsqs_pkg::NUM_CLS;
    localparam logic signed [AW-1:0] SCORE_HI = AW'((1 <<< (SW - 1)) - 1);
    localparam logic signed [AW-1:0] SCORE_LO = AW'(-(1 <<< (SW - 1)));

    // Running counters
    tsqs_pkg::t_cnt r_cls_cnt [NC];
    tsqs_pkg::t_cnt n_cls_cnt [NC];
    tsqs_pkg::t_cnt b_cls_cnt [NC];
    tsqs_pkg::t_cnt r_len, n_len, b_len;
    tsqs_pkg::t_cnt r_latin, n_latin, b_latin;
    tsqs_pkg::t_cnt r_mark, n_mark, b_mark;
    logic r_prevq, n_prevq;
    logic r_repeat, n_repeat, b_repeat;
    logic r_fffd, n_fffd, b_fffd;
    logic r_solid, n_solid, b_solid;
    logic is_marker;

    // Snapshot stage
    logic           r1_valid;
    tsqs_pkg::t_cnt r1_cls [NC];
    tsqs_pkg::t_cnt r1_len, r1_latin, r1_mark;
    logic           r1_repeat, r1_fffd, r1_solid;

    // Partial-sum stage
    logic           r2_valid;
    logic [CW+2:0]  r2_pos;
    logic [CW+5:0]  r2_neg;
    tsqs_pkg::t_cnt r2_dom;
    logic [CW+1:0]  r2_script;
    tsqs_pkg::t_cnt r2_latin, r2_mark;
    logic           r2_moji, r2_dmg, r2_fffd;

    // Output register
    logic                r_out_valid;
    tsqs_pkg::t_out_item r_out;

    // Stage flow
    logic out_free, s2_free, s1_free;
    assign out_free = !r_out_valid || i_ready;
    assign s2_free  = !r2_valid || out_free;
    assign s1_free  = !r1_valid || s2_free;
    assign o_pop    = i_q_valid && (!i_item.last || s1_free);

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Counter values including the current transaction
    assign is_marker = i_item.is_q || i_item.is_fffd;
    always_comb begin
        for (int i = 0; i < NC; i++) begin
            b_cls_cnt[i] = (i_item.cls == tsqs_pkg::CLS_W'(i)) ?
                           tsqs_pkg::sat_inc(r_cls_cnt[i]) : r_cls_cnt[i];
        end
        b_len    = tsqs_pkg::sat_inc(r_len);
        b_latin  = i_item.latin_like ? tsqs_pkg::sat_inc(r_latin) : r_latin;
        b_mark   = is_marker ? tsqs_pkg::sat_inc(r_mark) : r_mark;
        b_repeat = r_repeat || (i_item.is_q && r_prevq);
        b_fffd   = r_fffd || i_item.is_fffd;
        b_solid  = r_solid || (!is_marker && !i_item.is_space);
    end

    // Next counter state: cleared after the last unit of a string
    always_comb begin
        for (int i = 0; i < NC; i++) begin
            n_cls_cnt[i] = r_cls_cnt[i];
        end
        n_len    = r_len;
        n_latin  = r_latin;
        n_mark   = r_mark;
        n_prevq  = r_prevq;
        n_repeat = r_repeat;
        n_fffd   = r_fffd;
        n_solid  = r_solid;
        if (o_pop) begin
            if (i_item.last) begin
                for (int i = 0; i < NC; i++) begin
                    n_cls_cnt[i] = '0;
                end
                n_len    = '0;
                n_latin  = '0;
                n_mark   = '0;
                n_prevq  = 1'b0;
                n_repeat = 1'b0;
                n_fffd   = 1'b0;
                n_solid  = 1'b0;
            end else begin
                for (int i = 0; i < NC; i++) begin
                    n_cls_cnt[i] = b_cls_cnt[i];
                end
                n_len    = b_len;
                n_latin  = b_latin;
                n_mark   = b_mark;
                n_prevq  = i_item.is_q;
                n_repeat = b_repeat;
                n_fffd   = b_fffd;
                n_solid  = b_solid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NC; i++) begin
                r_cls_cnt[i] <= '0;
            end
            r_len    <= '0;
            r_latin  <= '0;
            r_mark   <= '0;
            r_prevq  <= 1'b0;
            r_repeat <= 1'b0;
            r_fffd   <= 1'b0;
            r_solid  <= 1'b0;
        end else begin
            for (int i = 0; i < NC; i++) begin
                r_cls_cnt[i] <= n_cls_cnt[i];
            end
            r_len    <= n_len;
            r_latin  <= n_latin;
            r_mark   <= n_mark;
            r_prevq  <= n_prevq;
            r_repeat <= n_repeat;
            r_fffd   <= n_fffd;
            r_solid  <= n_solid;
        end
    end

    // Stage 1: snapshot of final string statistics
    logic s1_load;
    assign s1_load = o_pop && i_item.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (s1_free) begin
            r1_valid <= s1_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            for (int i = 0; i < NC; i++) begin
                r1_cls[i] <= b_cls_cnt[i];
            end
            r1_len    <= b_len;
            r1_latin  <= b_latin;
            r1_mark   <= b_mark;
            r1_repeat <= b_repeat;
            r1_fffd   <= b_fffd;
            r1_solid  <= b_solid;
        end
    end

    // Stage 2: dominant script, partial sums and flags
    tsqs_pkg::t_cnt h, c, k, dom_hc, s2_dom;
    logic [CW+1:0]  s2_script;
    logic [CW+2:0]  s2_pos;
    logic [CW+5:0]  s2_neg;
    logic           s2_moji, s2_dmg;

    always_comb begin
        h         = r1_cls[tsqs_pkg::CLS_HANGUL];
        c         = r1_cls[tsqs_pkg::CLS_CJK];
        k         = r1_cls[tsqs_pkg::CLS_KANA];
        dom_hc    = (c > h) ? c : h;
        s2_dom    = (k > dom_hc) ? k : dom_hc;
        s2_script = (CW+2)'(h) + (CW+2)'(c) + (CW+2)'(k);
        // 6h+5c+7k-4(h+c+k) = 2h+c+3k; the dominant term adds 6*dom later
        s2_pos    = ((CW+3)'(h) << 1) + (CW+3)'(c) + ((CW+3)'(k) << 1) + (CW+3)'(k) +
                    (CW+3)'(r1_cls[tsqs_pkg::CLS_ASCII]) +
                    (CW+3)'(r1_cls[tsqs_pkg::CLS_OTHER]);
        s2_neg    = ((CW+6)'(r1_cls[tsqs_pkg::CLS_LATIN]) << 2) +
                    ((CW+6)'(r1_cls[tsqs_pkg::CLS_HALFKANA]) << 1) +
                    ((CW+6)'(r1_cls[tsqs_pkg::CLS_CONTROL]) << 5) -
                    ((CW+6)'(r1_cls[tsqs_pkg::CLS_CONTROL]) << 1);
        s2_moji   = (r1_len >= tsqs_pkg::t_cnt'(2)) && (r1_latin >= tsqs_pkg::t_cnt'(2)) &&
                    (((CW+3)'(r1_latin) << 2) + (CW+3)'(r1_latin) >= (CW+3)'(r1_len));
        priority if (r1_fffd) begin
            s2_dmg = 1'b1;
        end else if (r1_mark != '0 && r1_repeat) begin
            s2_dmg = !r1_solid ||
                     (r1_mark >= tsqs_pkg::t_cnt'(3) && s2_script == '0 &&
                      ((CW+1)'(r1_mark) << 1) >= (CW+1)'(r1_len));
        end else begin
            s2_dmg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (s2_free) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && r1_valid) begin
            r2_pos    <= s2_pos;
            r2_neg    <= s2_neg;
            r2_dom    <= s2_dom;
            r2_script <= s2_script;
            r2_latin  <= r1_latin;
            r2_mark   <= r1_mark;
            r2_moji   <= s2_moji;
            r2_dmg    <= s2_dmg;
            r2_fffd   <= r1_fffd;
        end
    end

    // Stage 3: final score, clamp and output register
    logic signed [AW-1:0] acc;
    logic signed [SW-1:0] score;

    always_comb begin
        acc = $signed(AW'(r2_pos)) + $signed(AW'(r2_dom) << 2) +
              $signed(AW'(r2_dom) << 1) - $signed(AW'(r2_neg));
        priority if (r2_fffd) begin
            score = tsqs_pkg::SCORE_FFFD;
        end else if (acc > SCORE_HI) begin
            score = SCORE_HI[SW-1:0];
        end else if (acc < SCORE_LO) begin
            score = SCORE_LO[SW-1:0];
        end else begin
            score = acc[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r2_valid) begin
            r_out.quality_score <= score;
            r_out.script_chars  <= tsqs_pkg::sat16(64'(r2_script));
            r_out.latin1_like   <= tsqs_pkg::sat16(64'(r2_latin));
            r_out.marker_total  <= tsqs_pkg::sat16(64'(r2_mark));
            r_out.mojibake_flag <= r2_moji;
            r_out.damage_flag   <= r2_dmg;
        end
    end

endmodule
`default_nettype wire

>>> rtl/tsqs_checker.sv
// Port-level checker for the text script quality scorer, bound to the top level
`default_nettype none
module tsqs_port_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_ready,
    input wire tsqs_pkg::t_in_item  i_unit,
    input wire logic                o_valid,
    input wire logic                i_ready,
    input wire tsqs_pkg::t_out_item o_result
);

    // A result transaction stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_result))
        else $error("result changed while stalled");

    // Reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

    // Mojibake needs at least two Latin-1-like units
    a_moji_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.mojibake_flag |-> o_result.latin1_like >= 16'd2)
        else $error("mojibake flag without Latin-1-like units");

    // Damage always comes with at least one marker
    a_damage_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.marker_total == 16'd0 |-> !o_result.damage_flag)
        else $error("damage flag without markers");

endmodule

bind text_script_quality_scorer_unit tsqs_port_checker u_tsqs_port_checker (.*);
`default_nettype wire
